// File: hdl/dptrm_pkg.sv
package dptrm_pkg;

    localparam int CFG_IW = 3;
    localparam int CFG_W  = 16;
    localparam int FC_W   = 5;
    localparam int LEN_W  = 32;
    localparam int CODE_W = 4;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IW-1:0] REG_PW    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_GAP1  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_GAP2  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WAIT1 = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WAIT2 = 3'd4;
    localparam logic [CFG_IW-1:0] REG_FC    = 3'd5;

    // raw item phases of one channel walk
    localparam logic [2:0] PH_PULSE = 3'd0;
    localparam logic [2:0] PH_GAP   = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_PAD   = 3'd3;
    localparam logic [2:0] PH_END   = 3'd4;

    // run types kept as type + 1
    localparam logic [1:0] TY_NEG  = 2'd0;
    localparam logic [1:0] TY_NONE = 2'd1;
    localparam logic [1:0] TY_POS  = 2'd2;

    localparam logic [1:0] SYM_NONE = 2'd0;
    localparam logic [1:0] SYM_POS  = 2'd1;

    localparam logic [CODE_W-1:0] CODE_MUL = 4'd3;

    typedef struct packed {
        logic load;
        logic clear;
        logic gather_start;
        logic step;
        logic emit;
        logic sel;
    } cmd_t;

    typedef struct packed {
        logic need_run;
        logic step_done;
        logic out_free;
    } stat_t;

    function automatic logic [1:0] sym_type(input logic [1:0] s);
        logic [1:0] t;
        if (s == SYM_NONE)
        begin
            t = TY_NONE;
        end
        else if (s == SYM_POS)
        begin
            t = TY_POS;
        end
        else
        begin
            t = TY_NEG;
        end
        return t;
    endfunction

endpackage

// File: hdl/dptrm_ctrl.sv
module dptrm_ctrl
    import dptrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  stat_t       stat,
    output cmd_t        cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [1:0] PREP_LAST = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        sel_next         = sel_reg;
        cmd              = '0;
        cmd.sel          = sel_reg;
        cmd.load         = accept && (operation == OP_LOAD);
        cmd.clear        = accept && (operation == OP_CLEAR);
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_FETCH))
                begin
                    state_next = S_PREP;
                    cnt_next   = '0;
                end
            end
            S_PREP:
            begin
                // lengths and padding settle through the datapath pipeline
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == PREP_LAST)
                begin
                    state_next = S_CHK;
                    sel_next   = 1'b0;
                end
            end
            S_CHK:
            begin
                if (stat.need_run)
                begin
                    cmd.gather_start = 1'b1;
                    state_next       = S_ISSUE;
                end
                else if (!sel_reg)
                begin
                    sel_next = 1'b1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_ISSUE:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.step = 1'b1;
                if (stat.step_done)
                begin
                    if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        state_next = S_CHK;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// File: hdl/dptrm_dp.sv
module dptrm_dp
    import dptrm_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [1:0]        symbol,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              seg_valid,
    output logic [CODE_W-1:0] combined_code,
    output logic [LEN_W-1:0]  seg_length,
    output logic              seg_last
);

    localparam int CW  = $clog2(MAX_SYMBOLS + 1);
    localparam int AW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int XW  = (CW > FC_W) ? CW : FC_W;
    localparam int PRW = CFG_W + CW;
    localparam int TW  = PRW + 2;

    logic [1:0]       mem [MAX_SYMBOLS];
    logic [1:0]       rd_reg;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;

    logic [CW-1:0]    loaded_reg;
    logic [CFG_W-1:0] pw_reg, gap1_reg, gap2_reg, wait1_reg, wait2_reg;
    logic [FC_W-1:0]  fc_reg;
    logic             restart;

    logic [CW-1:0]    k1_reg, k2_reg, k1_next, k2_next;
    logic [PRW-1:0]   pp1_reg, pg1_reg, pp2_reg, pg2_reg;
    logic [CW-1:0]    km1_1, km1_2;
    logic [TW-1:0]    t1_reg, t2_reg, pad1_reg, pad2_reg;

    logic [CW-1:0]    j1_reg, j2_reg;
    logic [2:0]       ph1_reg, ph2_reg;
    logic [LEN_W-1:0] rl1_reg, rl2_reg;
    logic [1:0]       rt1_reg, rt2_reg;

    logic [LEN_W-1:0] acc_len_reg;
    logic [1:0]       acc_type_reg;
    logic             found_reg;

    logic             out_valid_reg;
    logic             seg_valid_reg, seg_last_reg;
    logic [CODE_W-1:0] code_reg;
    logic [LEN_W-1:0] seg_len_reg;

    // walk of the selected channel
    logic [CW-1:0]    cur_j, cur_k, nxt_j;
    logic [2:0]       cur_ph, eff_ph, nxt_ph;
    logic [CFG_W-1:0] cur_gap, cur_wait;
    logic [TW-1:0]    cur_pad;
    logic [1:0]       it_type;
    logic [LEN_W-1:0] it_len;
    logic             it_end;
    logic             step_done;

    logic [LEN_W-1:0] g;
    logic             fire;

    assign restart = cmd.load || cmd.clear || (cfg_we && (cfg_index <= REG_FC));
    assign mem_we  = cmd.load && (loaded_reg < CW'(MAX_SYMBOLS));

    // ---------------- config and symbol count ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg     <= 16'd1;
            gap1_reg   <= '0;
            gap2_reg   <= '0;
            wait1_reg  <= '0;
            wait2_reg  <= '0;
            fc_reg     <= '0;
            loaded_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PW:    pw_reg    <= cfg_data;
                    REG_GAP1:  gap1_reg  <= cfg_data;
                    REG_GAP2:  gap2_reg  <= cfg_data;
                    REG_WAIT1: wait1_reg <= cfg_data;
                    REG_WAIT2: wait2_reg <= cfg_data;
                    REG_FC:    fc_reg    <= cfg_data[FC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.clear)
            begin
                loaded_reg <= '0;
            end
            else if (mem_we)
            begin
                loaded_reg <= loaded_reg + CW'(1);
            end
        end
    end

    // ---------------- symbol store ----------------
    assign rd_addr = cmd.sel ? AW'(k1_reg + j2_reg) : AW'(j1_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[loaded_reg[AW-1:0]] <= symbol;
        end
        rd_reg <= mem[rd_addr];
    end

    // ---------------- channel totals and padding ----------------
    always_comb
    begin
        k1_next = (XW'(fc_reg) < XW'(loaded_reg)) ? CW'(fc_reg) : loaded_reg;
        k2_next = loaded_reg - k1_next;
        km1_1   = (k1_reg == '0) ? '0 : k1_reg - CW'(1);
        km1_2   = (k2_reg == '0) ? '0 : k2_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        pp1_reg  <= PRW'(pw_reg) * PRW'(k1_reg);
        pg1_reg  <= PRW'(gap1_reg) * PRW'(km1_1);
        pp2_reg  <= PRW'(pw_reg) * PRW'(k2_reg);
        pg2_reg  <= PRW'(gap2_reg) * PRW'(km1_2);
        t1_reg   <= TW'(pp1_reg) + TW'(pg1_reg) + TW'(wait1_reg);
        t2_reg   <= TW'(pp2_reg) + TW'(pg2_reg) + TW'(wait2_reg);
        pad1_reg <= (t2_reg > t1_reg) ? t2_reg - t1_reg : '0;
        pad2_reg <= (t1_reg > t2_reg) ? t1_reg - t2_reg : '0;
    end

    // ---------------- raw item at the cursor ----------------
    always_comb
    begin
        cur_j    = cmd.sel ? j2_reg : j1_reg;
        cur_ph   = cmd.sel ? ph2_reg : ph1_reg;
        cur_k    = cmd.sel ? k2_reg : k1_reg;
        cur_gap  = cmd.sel ? gap2_reg : gap1_reg;
        cur_wait = cmd.sel ? wait2_reg : wait1_reg;
        cur_pad  = cmd.sel ? pad2_reg : pad1_reg;

        // a channel with no symbols opens with its wait
        eff_ph   = ((cur_ph == PH_PULSE) && (cur_k == '0)) ? PH_WAIT : cur_ph;

        it_type  = TY_NONE;
        it_len   = '0;
        it_end   = 1'b0;
        nxt_j    = cur_j;
        nxt_ph   = PH_END;
        case (eff_ph)
            PH_PULSE:
            begin
                it_type = sym_type(rd_reg);
                it_len  = LEN_W'(pw_reg);
                nxt_ph  = ((cur_j + CW'(1)) == cur_k) ? PH_WAIT : PH_GAP;
            end
            PH_GAP:
            begin
                it_len = LEN_W'(cur_gap);
                nxt_j  = cur_j + CW'(1);
                nxt_ph = PH_PULSE;
            end
            PH_WAIT:
            begin
                it_len = LEN_W'(cur_wait);
                nxt_ph = PH_PAD;
            end
            PH_PAD:
            begin
                it_len = LEN_W'(cur_pad);
                nxt_ph = PH_END;
            end
            default:
            begin
                it_end = 1'b1;
            end
        endcase

        step_done = it_end || ((it_len != '0) && found_reg && (it_type != acc_type_reg));
    end

    always_comb
    begin
        stat.need_run  = (cmd.sel ? (rl2_reg == '0) : (rl1_reg == '0)) && (cur_ph != PH_END);
        stat.step_done = step_done;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // ---------------- run gathering ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.gather_start)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.step && !step_done && (it_len != '0))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && !step_done && (it_len != '0))
        begin
            if (!found_reg)
            begin
                acc_type_reg <= it_type;
                acc_len_reg  <= it_len;
            end
            else
            begin
                acc_len_reg <= acc_len_reg + it_len;
            end
        end
    end

    // ---------------- segment split ----------------
    assign g    = (rl1_reg < rl2_reg) ? rl1_reg : rl2_reg;
    assign fire = (rl1_reg != '0) && (rl2_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j1_reg  <= '0;
            j2_reg  <= '0;
            ph1_reg <= PH_PULSE;
            ph2_reg <= PH_PULSE;
            rl1_reg <= '0;
            rl2_reg <= '0;
            rt1_reg <= '0;
            rt2_reg <= '0;
        end
        else if (restart)
        begin
            j1_reg  <= '0;
            j2_reg  <= '0;
            ph1_reg <= PH_PULSE;
            ph2_reg <= PH_PULSE;
            rl1_reg <= '0;
            rl2_reg <= '0;
            rt1_reg <= '0;
            rt2_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (step_done)
            begin
                if (found_reg)
                begin
                    if (cmd.sel)
                    begin
                        rl2_reg <= acc_len_reg;
                        rt2_reg <= acc_type_reg;
                    end
                    else
                    begin
                        rl1_reg <= acc_len_reg;
                        rt1_reg <= acc_type_reg;
                    end
                end
            end
            else if (cmd.sel)
            begin
                j2_reg  <= nxt_j;
                ph2_reg <= nxt_ph;
            end
            else
            begin
                j1_reg  <= nxt_j;
                ph1_reg <= nxt_ph;
            end
        end
        else if (cmd.emit && fire)
        begin
            rl1_reg <= rl1_reg - g;
            rl2_reg <= rl2_reg - g;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (fire)
            begin
                seg_valid_reg <= 1'b1;
                code_reg      <= CODE_W'(rt1_reg) + CODE_W'(rt2_reg) * CODE_MUL;
                seg_len_reg   <= g;
                seg_last_reg  <= (rl1_reg == rl2_reg) && (ph1_reg == PH_END)
                                 && (ph2_reg == PH_END);
            end
            else
            begin
                seg_valid_reg <= 1'b0;
                code_reg      <= '0;
                seg_len_reg   <= '0;
                seg_last_reg  <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign seg_valid     = seg_valid_reg;
    assign combined_code = code_reg;
    assign seg_length    = seg_len_reg;
    assign seg_last      = seg_last_reg;

endmodule

// File: hdl/dual_pulse_train_run_merger.sv
// channel   signals                                  direction
// config    cfg_we cfg_index cfg_data                in, write only, no wait
// input     in_valid in_ready operation symbol        in, one beat per command
// output    out_valid out_ready seg_valid             out, one beat per fetch
//           combined_code seg_length seg_last
//
// load, clear and unknown commands are taken in the idle state, which they do not leave
// fetch: setup states settle totals and padding, one check per channel, an issue
// and an evaluate state per raw item walked through the registered-read store and
// to close each gathered run, and the emit state loads the output register
// reset clears config to defaults, empties the symbol list and restarts the walk
// a held output beat stalls the next fetch in its emit state only
module dual_pulse_train_run_merger
    import dptrm_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [1:0]        symbol,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              seg_valid,
    output logic [CODE_W-1:0] combined_code,
    output logic [LEN_W-1:0]  seg_length,
    output logic              seg_last
);

    cmd_t  cmd;
    stat_t stat;

    dptrm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    dptrm_dp
    #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .symbol        (symbol),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seg_valid     (seg_valid),
        .combined_code (combined_code),
        .seg_length    (seg_length),
        .seg_last      (seg_last)
    );

endmodule

// File: hdl/dptrm_checker.sv
module dptrm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        seg_valid,
    input logic [3:0]  combined_code,
    input logic [31:0] seg_length,
    input logic        seg_last
);

    // held beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seg_valid)
            && $stable(combined_code) && $stable(seg_length) && $stable(seg_last))
        else $error("output beat changed while stalled");

    // an empty answer carries all zeros
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !seg_valid |-> combined_code == 4'd0 && seg_length == 32'd0
            && !seg_last)
        else $error("empty answer with nonzero fields");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seg_valid |-> seg_length != 32'd0)
        else $error("zero length segment");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seg_valid |-> combined_code <= 4'd8)
        else $error("combined code out of range");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seg_last |-> seg_valid)
        else $error("last flag on an empty answer");

endmodule

bind dual_pulse_train_run_merger dptrm_checker u_dptrm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .seg_valid     (seg_valid),
    .combined_code (combined_code),
    .seg_length    (seg_length),
    .seg_last      (seg_last)
);
